// ===== design/tcl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcl_pkg: shared types and constants
// Codes, result record and register map of the link decoder.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int unsigned FREQ_DIGITS = 9;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // Register index taken from paddr[2].
  localparam logic CFG_IDX_TIMEOUT = 1'b0;

  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_SNAP = 1'b1;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_POLL = 2'd1,
    FUNC_SHOW = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CMD_IF   = 2'd0,
    CMD_TX   = 2'd1,
    CMD_PC   = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IF0   = 3'd0,
    PH_TX1   = 3'd1,
    PH_PC2   = 3'd2,
    PH_TX3   = 3'd3,
    PH_IF4   = 3'd4,
    PH_TX5   = 3'd5,
    PH_IDLE6 = 3'd6
  } phase_e;

  typedef struct packed {
    logic        out_kind;
    logic [1:0]  command;
    logic [31:0] freq_a;
    logic [31:0] freq_b;
    logic [7:0]  mode_code;
    logic [15:0] tx_power;
    logic [7:0]  tx_state;
    logic [7:0]  power_on;
    logic        display_update;
    logic        changed;
  } result_t;

endpackage

// ===== design/tcl_cfg.sv =====
// ----------------------------------------------------------------------------
// tcl_cfg: configuration register port
// APB-style access to the reply timeout register.
// ----------------------------------------------------------------------------
module tcl_cfg
  import tcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  timeout_o
);

  logic [7:0] timeout_q;
  logic [7:0] timeout_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_IDX_TIMEOUT);

  always_comb begin
    timeout_d = timeout_q;
    if (wr_en) begin
      timeout_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata    = (paddr[2] == CFG_IDX_TIMEOUT) ? {24'd0, timeout_q} : 32'd0;
  assign timeout_o = timeout_q;

endmodule

// ===== design/tcl_core.sv =====
// ----------------------------------------------------------------------------
// tcl_core: reply decoder and poll sequencer
// Holds the decoder state and works out one item per executed cycle.
// ----------------------------------------------------------------------------
module tcl_core
  import tcl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       exec_i,
  input  logic [1:0] func_i,
  input  logic [7:0] rx_byte_i,
  input  logic       last_byte_i,
  input  logic [7:0] timeout_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [4:0] IF_DIG_LO  = 5'd5;
  localparam logic [4:0] IF_DIG_END = 5'(5 + FREQ_DIGITS);
  localparam logic [4:0] FX_DIG_END = 5'(2 + FREQ_DIGITS);
  localparam logic [4:0] PC_DIG_END = 5'd5;
  localparam logic [4:0] IF_MODE_AT = 5'd21;
  localparam logic [4:0] DIG_AT     = 5'd2;
  localparam logic [4:0] IDX_MAX    = 5'd31;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  phase_e      phase_q, phase_d;
  logic [7:0]  timer_q, timer_d;
  logic [4:0]  idx_q, idx_d;
  logic [7:0]  hf_q, hf_d, hs_q, hs_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] vfo_a_q, vfo_a_d, vfo_b_q, vfo_b_d, seen_q, seen_d;
  logic [31:0] shown_q, shown_d;
  logic [7:0]  mode_q, mode_d, shown_mode_q, shown_mode_d;
  logic [15:0] power_q, power_d;
  logic [7:0]  tx_q, tx_d, pon_q, pon_d;
  logic        refresh_q, refresh_d;
  logic        chg;
  logic        kind;
  cmd_e        cmd;

  function automatic logic hdr(input logic [7:0] f, input logic [7:0] s,
                               input logic [7:0] c1, input logic [7:0] c2);
    return (f == c1) && (s == c2);
  endfunction

  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] b);
    return (acc << 3) + (acc << 1) + {24'd0, b - ASCII_ZERO};
  endfunction

  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    idx_d        = idx_q;
    hf_d         = hf_q;
    hs_d         = hs_q;
    acc_d        = acc_q;
    vfo_a_d      = vfo_a_q;
    vfo_b_d      = vfo_b_q;
    seen_d       = seen_q;
    shown_d      = shown_q;
    mode_d       = mode_q;
    shown_mode_d = shown_mode_q;
    power_d      = power_q;
    tx_d         = tx_q;
    pon_d        = pon_q;
    refresh_d    = refresh_q;
    chg          = 1'b0;
    kind         = KIND_SNAP;
    cmd          = CMD_NONE;
    res_valid_o  = 1'b0;
    case (func_e'(func_i))
      FUNC_BYTE: begin
        res_valid_o = last_byte_i;
        if (idx_q == 5'd0) begin
          hf_d  = rx_byte_i;
          hs_d  = 8'd0;
          acc_d = 32'd0;
        end else if (idx_q == 5'd1) begin
          hs_d = rx_byte_i;
        end else if (hdr(hf_q, hs_q, "I", "F")) begin
          if (idx_q >= IF_DIG_LO && idx_q < IF_DIG_END) begin
            acc_d = add_digit(acc_q, rx_byte_i);
          end
          if (idx_q == IF_MODE_AT) begin
            mode_d = rx_byte_i;
          end
        end else if (hdr(hf_q, hs_q, "F", "A") || hdr(hf_q, hs_q, "F", "B")) begin
          if (idx_q < FX_DIG_END) begin
            acc_d = add_digit(acc_q, rx_byte_i);
          end
        end else if (hdr(hf_q, hs_q, "P", "C")) begin
          if (idx_q < PC_DIG_END) begin
            acc_d = add_digit(acc_q, rx_byte_i);
          end
        end else if (hdr(hf_q, hs_q, "T", "X") || hdr(hf_q, hs_q, "P", "S")) begin
          if (idx_q == DIG_AT) begin
            acc_d = {24'd0, rx_byte_i};
          end
        end

        if (!last_byte_i) begin
          if (idx_q < IDX_MAX) begin
            idx_d = idx_q + 5'd1;
          end
        end else begin
          pon_d   = 8'd1;
          timer_d = timeout_i;
          idx_d   = 5'd0;
          if (idx_q != 5'd0) begin
            if (hdr(hf_d, hs_d, "I", "F") || hdr(hf_d, hs_d, "F", "A")) begin
              vfo_a_d = acc_d;
              if (acc_d != shown_q ||
                  (hdr(hf_d, hs_d, "I", "F") && mode_d != shown_mode_q)) begin
                chg       = 1'b1;
                refresh_d = 1'b1;
              end
            end else if (hdr(hf_d, hs_d, "F", "B")) begin
              vfo_b_d = acc_d;
              if (acc_d != seen_q) begin
                chg    = 1'b1;
                seen_d = acc_d;
              end
            end else if (hdr(hf_d, hs_d, "P", "C")) begin
              power_d   = {1'b0, acc_d[15:1]};
              refresh_d = 1'b1;
            end else if (hdr(hf_d, hs_d, "T", "X")) begin
              if (idx_q >= DIG_AT) begin
                tx_d = acc_d[7:0] - ASCII_ZERO;
              end
              chg       = 1'b1;
              refresh_d = 1'b1;
            end else if (hdr(hf_d, hs_d, "P", "S")) begin
              if (idx_q >= DIG_AT) begin
                pon_d = acc_d[7:0] - ASCII_ZERO;
              end
              chg = 1'b1;
            end
          end
        end
      end
      FUNC_POLL: begin
        res_valid_o = 1'b1;
        kind        = KIND_POLL;
        case (phase_q)
          PH_IF0: begin
            cmd     = CMD_IF;
            phase_d = (shown_q != vfo_a_q) ? PH_IF0 : PH_TX1;
          end
          PH_TX1: begin
            cmd     = CMD_TX;
            phase_d = PH_PC2;
          end
          PH_PC2: begin
            cmd     = CMD_PC;
            phase_d = PH_TX3;
          end
          PH_TX3: begin
            cmd     = CMD_TX;
            phase_d = PH_IF4;
          end
          PH_IF4: begin
            cmd     = CMD_IF;
            phase_d = PH_TX5;
            if (timer_q != 8'd0) begin
              timer_d = timer_q - 8'd1;
              if (timer_q == 8'd1) begin
                vfo_a_d   = 32'd0;
                refresh_d = 1'b1;
              end
            end
          end
          PH_TX5: begin
            cmd     = CMD_TX;
            phase_d = PH_IDLE6;
          end
          default: begin
            cmd     = CMD_NONE;
            phase_d = PH_IF0;
          end
        endcase
      end
      FUNC_SHOW: begin
        shown_d      = vfo_a_q;
        shown_mode_d = mode_q;
        refresh_d    = 1'b0;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IF0;
      timer_q      <= 8'd0;
      idx_q        <= 5'd0;
      hf_q         <= 8'd0;
      hs_q         <= 8'd0;
      acc_q        <= 32'd0;
      vfo_a_q      <= 32'd0;
      vfo_b_q      <= 32'd0;
      seen_q       <= 32'd0;
      shown_q      <= 32'd0;
      mode_q       <= 8'd0;
      shown_mode_q <= 8'd0;
      power_q      <= 16'd0;
      tx_q         <= 8'd0;
      pon_q        <= 8'd0;
      refresh_q    <= 1'b0;
    end else if (exec_i) begin
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      idx_q        <= idx_d;
      hf_q         <= hf_d;
      hs_q         <= hs_d;
      acc_q        <= acc_d;
      vfo_a_q      <= vfo_a_d;
      vfo_b_q      <= vfo_b_d;
      seen_q       <= seen_d;
      shown_q      <= shown_d;
      mode_q       <= mode_d;
      shown_mode_q <= shown_mode_d;
      power_q      <= power_d;
      tx_q         <= tx_d;
      pon_q        <= pon_d;
      refresh_q    <= refresh_d;
    end
  end

  always_comb begin
    res_o.out_kind       = kind;
    res_o.command        = cmd;
    res_o.freq_a         = vfo_a_d;
    res_o.freq_b         = vfo_b_d;
    res_o.mode_code      = mode_d;
    res_o.tx_power       = power_d;
    res_o.tx_state       = tx_d;
    res_o.power_on       = pon_d;
    res_o.display_update = refresh_d;
    res_o.changed        = chg;
  end

  // A finished reply always starts the next message at its header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && func_i == FUNC_BYTE && last_byte_i |=> idx_q == 5'd0)
    else $error("byte index not cleared after the last byte");

  // The poll phase moves from the last command phase to the idle phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && func_i == FUNC_POLL && phase_q == PH_TX5 |=> phase_q == PH_IDLE6)
    else $error("poll phase skipped the idle phase");

endmodule

// ===== design/transceiver_cat_link_decoder.sv =====
// ----------------------------------------------------------------------------
// transceiver_cat_link_decoder: status decoder for a transceiver control link
// Input register, combinational decode and an output register.
// Each result is decoded from the input register into the output register.
// Throughput: one item per cycle; the input register frees as the item
// executes, and execution stalls only while a result waits at the output.
// Reset: all decoder state clears to zero and the reply timeout loads 10.
// ----------------------------------------------------------------------------
module transceiver_cat_link_decoder
  import tcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [1:0]  command_o,
  output logic [31:0] freq_a_o,
  output logic [31:0] freq_b_o,
  output logic [7:0]  mode_code_o,
  output logic [15:0] tx_power_o,
  output logic [7:0]  tx_state_o,
  output logic [7:0]  power_on_o,
  output logic        display_update_o,
  output logic        changed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_valid_q;
  logic [1:0] func_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       res_valid;
  logic       out_free;
  logic       exec;
  logic [7:0] timeout;

  tcl_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout)
  );

  tcl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exec_i      (exec),
    .func_i      (func_q),
    .rx_byte_i   (byte_q),
    .last_byte_i (last_q),
    .timeout_i   (timeout),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign exec       = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q <= func_i;
      byte_q <= rx_byte_i;
      last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= exec && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && exec && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_q.out_kind;
  assign command_o        = out_q.command;
  assign freq_a_o         = out_q.freq_a;
  assign freq_b_o         = out_q.freq_b;
  assign mode_code_o      = out_q.mode_code;
  assign tx_power_o       = out_q.tx_power;
  assign tx_state_o       = out_q.tx_state;
  assign power_on_o       = out_q.power_on;
  assign display_update_o = out_q.display_update;
  assign changed_o        = out_q.changed;

  // An empty input register always takes the next transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled while the input register is empty");

  // A status snapshot never names a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_SNAP |-> command_o == CMD_NONE)
    else $error("snapshot carries a command");

  // A poll result never reports a change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_POLL |-> !changed_o)
    else $error("poll result reports a change");

  // A stalled result holds while the decoder waits for it to leave.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_q))
    else $error("stalled result was overwritten");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: link decoder check
// Sends reply bytes, poll ticks and display acknowledges to the decoder,
// predicts every status snapshot and poll result from a behavioral copy of
// the decoder kept here, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import tcl_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  localparam logic [2:0]  ADDR_TIMEOUT  = {CFG_IDX_TIMEOUT, 2'b00};
  localparam logic [7:0]  ASCII_ZERO    = 8'h30;
  localparam logic [15:0] HDR_IF        = "IF";
  localparam logic [15:0] HDR_FA        = "FA";
  localparam logic [15:0] HDR_FB        = "FB";
  localparam logic [15:0] HDR_PC        = "PC";
  localparam logic [15:0] HDR_TX        = "TX";
  localparam logic [15:0] HDR_PS        = "PS";
  localparam int          IF_FREQ_POS   = 5;
  localparam int          IF_MODE_POS   = 21;
  localparam int          VFO_FREQ_POS  = 2;
  localparam int          PC_END_POS    = 5;
  localparam int          STATE_POS     = 2;
  localparam int          IF_REPLY_LEN  = 23;
  localparam int          VFO_REPLY_LEN = 12;
  localparam int          PC_REPLY_LEN  = 6;
  localparam int          STATE_REPLY_LEN = 4;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          MAX_REPORTS   = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_BYTE;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        out_kind_o;
  logic [1:0]  command_o;
  logic [31:0] freq_a_o;
  logic [31:0] freq_b_o;
  logic [7:0]  mode_code_o;
  logic [15:0] tx_power_o;
  logic [7:0]  tx_state_o;
  logic [7:0]  power_on_o;
  logic        display_update_o;
  logic        changed_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Behavioral copy of the decoder state.
  logic [7:0]  timeout_cfg = TIMEOUT_RESET;
  phase_e      phase_q = PH_IF0;
  logic [7:0]  reply_timer = 8'd0;
  logic [4:0]  byte_pos = 5'd0;
  logic [7:0]  hdr_hi = 8'd0;
  logic [7:0]  hdr_lo = 8'd0;
  logic [31:0] digit_acc = 32'd0;
  logic [31:0] vfo_a_q = 32'd0;
  logic [31:0] vfo_b_q = 32'd0;
  logic [31:0] vfo_b_seen = 32'd0;
  logic [31:0] shown_freq = 32'd0;
  logic [7:0]  mode_q = 8'd0;
  logic [7:0]  shown_mode = 8'd0;
  logic [15:0] power_q = 16'd0;
  logic [7:0]  tx_q = 8'd0;
  logic [7:0]  pwr_on_q = 8'd0;
  logic        refresh_q = 1'b0;

  result_t     pending_status[$];
  result_t     expected_head;
  int          errors = 0;
  int          items_sent = 0;
  int          stuck_cycles = 0;
  logic        no_idle = 1'b0;
  logic        hold_rx = 1'b0;

  transceiver_cat_link_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .rx_byte_i        (rx_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_kind_o       (out_kind_o),
    .command_o        (command_o),
    .freq_a_o         (freq_a_o),
    .freq_b_o         (freq_b_o),
    .mode_code_o      (mode_code_o),
    .tx_power_o       (tx_power_o),
    .tx_state_o       (tx_state_o),
    .power_on_o       (power_on_o),
    .display_update_o (display_update_o),
    .changed_o        (changed_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] add_digit(logic [31:0] acc, logic [7:0] b);
    logic [7:0] d;
    d = b - ASCII_ZERO;
    return acc * 32'd10 + {24'd0, d};
  endfunction

  function automatic result_t status_of(logic kind, cmd_e cmd, logic chg);
    result_t r;
    r.out_kind       = kind;
    r.command        = cmd;
    r.freq_a         = vfo_a_q;
    r.freq_b         = vfo_b_q;
    r.mode_code      = mode_q;
    r.tx_power       = power_q;
    r.tx_state       = tx_q;
    r.power_on       = pwr_on_q;
    r.display_update = refresh_q;
    r.changed        = chg;
    return r;
  endfunction

  task automatic decode_item(input logic [1:0] fn, input logic [7:0] b, input logic last);
    logic [4:0]  pos;
    logic [15:0] hdr;
    logic        chg;
    cmd_e        cmd;
    pos = byte_pos;
    chg = 1'b0;
    hdr = {hdr_hi, hdr_lo};
    case (fn)
      FUNC_BYTE: begin
        if (pos == 5'd0) begin
          hdr_hi = b;
          hdr_lo = 8'd0;
          digit_acc = 32'd0;
        end else if (pos == 5'd1) begin
          hdr_lo = b;
        end else if (hdr == HDR_IF) begin
          if (pos >= IF_FREQ_POS && pos < IF_FREQ_POS + FREQ_DIGITS) begin
            digit_acc = add_digit(digit_acc, b);
          end
          if (pos == IF_MODE_POS) begin
            mode_q = b;
          end
        end else if (hdr == HDR_FA || hdr == HDR_FB) begin
          if (pos < VFO_FREQ_POS + FREQ_DIGITS) begin
            digit_acc = add_digit(digit_acc, b);
          end
        end else if (hdr == HDR_PC) begin
          if (pos < PC_END_POS) begin
            digit_acc = add_digit(digit_acc, b);
          end
        end else if (hdr == HDR_TX || hdr == HDR_PS) begin
          if (pos == STATE_POS) begin
            digit_acc = {24'd0, b};
          end
        end
        if (!last) begin
          if (byte_pos != 5'd31) begin
            byte_pos = byte_pos + 5'd1;
          end
        end else begin
          hdr = {hdr_hi, hdr_lo};
          pwr_on_q = 8'd1;
          reply_timer = timeout_cfg;
          if (pos >= 5'd1) begin
            if (hdr == HDR_IF || hdr == HDR_FA) begin
              vfo_a_q = digit_acc;
              if (vfo_a_q != shown_freq || (hdr == HDR_IF && mode_q != shown_mode)) begin
                chg = 1'b1;
                refresh_q = 1'b1;
              end
            end else if (hdr == HDR_FB) begin
              vfo_b_q = digit_acc;
              if (vfo_b_q != vfo_b_seen) begin
                chg = 1'b1;
                vfo_b_seen = vfo_b_q;
              end
            end else if (hdr == HDR_PC) begin
              power_q = digit_acc[15:0] >> 1;
              refresh_q = 1'b1;
            end else if (hdr == HDR_TX) begin
              if (pos >= STATE_POS) begin
                tx_q = digit_acc[7:0] - ASCII_ZERO;
              end
              chg = 1'b1;
              refresh_q = 1'b1;
            end else if (hdr == HDR_PS) begin
              if (pos >= STATE_POS) begin
                pwr_on_q = digit_acc[7:0] - ASCII_ZERO;
              end
              chg = 1'b1;
            end
          end
          byte_pos = 5'd0;
          pending_status.push_back(status_of(KIND_SNAP, CMD_NONE, chg));
        end
      end
      FUNC_POLL: begin
        case (phase_q)
          PH_IF0: begin
            cmd = CMD_IF;
            if (shown_freq != vfo_a_q) begin
              phase_q = PH_IF0;
            end else begin
              phase_q = PH_TX1;
            end
          end
          PH_TX1: begin
            cmd = CMD_TX;
            phase_q = PH_PC2;
          end
          PH_PC2: begin
            cmd = CMD_PC;
            phase_q = PH_TX3;
          end
          PH_TX3: begin
            cmd = CMD_TX;
            phase_q = PH_IF4;
          end
          PH_IF4: begin
            cmd = CMD_IF;
            phase_q = PH_TX5;
            if (reply_timer != 8'd0) begin
              reply_timer = reply_timer - 8'd1;
              if (reply_timer == 8'd0) begin
                vfo_a_q = 32'd0;
                refresh_q = 1'b1;
              end
            end
          end
          PH_TX5: begin
            cmd = CMD_TX;
            phase_q = PH_IDLE6;
          end
          default: begin
            cmd = CMD_NONE;
            phase_q = PH_IF0;
          end
        endcase
        pending_status.push_back(status_of(KIND_POLL, cmd, 1'b0));
      end
      FUNC_SHOW: begin
        shown_freq = vfo_a_q;
        shown_mode = mode_q;
        refresh_q = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Result checker: every output transfer is matched with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result transfer with no prediction waiting");
      end else begin
        expected_head = pending_status.pop_front();
        compare_field("out_kind", out_kind_o, expected_head.out_kind);
        compare_field("command", command_o, expected_head.command);
        compare_field("freq_a", freq_a_o, expected_head.freq_a);
        compare_field("freq_b", freq_b_o, expected_head.freq_b);
        compare_field("mode_code", mode_code_o, expected_head.mode_code);
        compare_field("tx_power", tx_power_o, expected_head.tx_power);
        compare_field("tx_state", tx_state_o, expected_head.tx_state);
        compare_field("power_on", power_on_o, expected_head.power_on);
        compare_field("display_update", display_update_o, expected_head.display_update);
        compare_field("changed", changed_o, expected_head.changed);
      end
    end
  end

  // Receiver: random stalls, a stall-free stretch, and one long hold-off.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("FAIL transceiver_cat_link_decoder");
    $finish;
  end

  task automatic send_item(input logic [1:0] fn, input logic [7:0] b, input logic last);
    if (!no_idle && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= fn;
    rx_byte_i   <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_item(fn, b, last);
    if (fn != FUNC_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(FUNC_BYTE, s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_reply(input logic [15:0] hdr, input int len, input int noise_pct);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        b = hdr[15:8];
      end else if (i == 1) begin
        b = hdr[7:0];
      end else if ($urandom_range(99) < noise_pct) begin
        b = 8'($urandom_range(255));
      end else begin
        b = ASCII_ZERO + 8'($urandom_range(9));
      end
      send_item(FUNC_BYTE, b, i == len - 1);
    end
  endtask

  task automatic send_polls(input int count);
    repeat (count) send_item(FUNC_POLL, 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] ticks);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TIMEOUT;
    pwdata  <= {24'd0, ticks};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    timeout_cfg = ticks;
  endtask

  task automatic random_reply();
    logic [15:0] hdr;
    int          len;
    case ($urandom_range(5))
      0: begin hdr = HDR_IF; len = IF_REPLY_LEN; end
      1: begin hdr = HDR_FA; len = VFO_REPLY_LEN; end
      2: begin hdr = HDR_FB; len = VFO_REPLY_LEN; end
      3: begin hdr = HDR_PC; len = PC_REPLY_LEN; end
      4: begin hdr = HDR_TX; len = STATE_REPLY_LEN; end
      default: begin hdr = HDR_PS; len = STATE_REPLY_LEN; end
    endcase
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(1, 40);
    end
    send_reply(hdr, len, 5);
  endtask

  task automatic random_segment(input int quota);
    int stop_at;
    int pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        random_reply();
      end else if (pick < 62) begin
        send_polls(1);
      end else if (pick < 72) begin
        send_item(FUNC_SHOW, 8'($urandom), 1'($urandom));
      end else if (pick < 78) begin
        send_reply(16'($urandom), $urandom_range(1, 30), 50);
      end else if (pick < 82) begin
        send_item(FUNC_UNUSED, 8'($urandom), 1'($urandom));
      end else if (pick < 90) begin
        send_item(FUNC_BYTE, 8'($urandom), 1'($urandom));
      end else begin
        send_polls(7);
      end
    end
  endtask

  task automatic test_directed_replies();
    send_text("IF00001407400000000002;");
    send_item(FUNC_SHOW, 8'h00, 1'b0);
    send_text("IF00001407400000000003;");
    send_text("FA007100000;");
    send_text("FB014250000;");
    send_text("FB014250000;");
    send_text("PC100;");
    send_text("TX1;");
    send_text("TX0;");
    send_text("PS0;");
    send_text("PS1;");
    send_text("TX");
    send_text("PS");
    send_text("I");
    send_text("IF0001407");
    send_text("FA12345678901234567890123456789012345678");
    send_text("ZZ123;");
    send_text("FA:?AB0xyz;");
    send_item(FUNC_BYTE, "F", 1'b0);
    send_item(FUNC_BYTE, "A", 1'b0);
    repeat (FREQ_DIGITS) send_item(FUNC_BYTE, 8'hFF, 1'b0);
    send_item(FUNC_BYTE, 8'h00, 1'b1);
    send_text("PC");
    send_item(FUNC_UNUSED, 8'hFF, 1'b1);
    send_item(FUNC_SHOW, 8'hFF, 1'b1);
    wait_idle();
  endtask

  // Runs on the reset timeout: ten passes through phase four clear frequency A.
  task automatic test_poll_sequence();
    send_text("FA007000000;");
    send_polls(3);
    send_item(FUNC_SHOW, 8'h00, 1'b0);
    send_polls(72);
    send_item(FUNC_SHOW, 8'h00, 1'b0);
    send_polls(8);
    wait_idle();
  endtask

  task automatic test_reply_timeout();
    write_timeout(8'd1);
    send_text("FA003500000;");
    send_item(FUNC_SHOW, 8'h00, 1'b0);
    send_polls(14);
    wait_idle();
    write_timeout(8'd0);
    send_text("FA003500000;");
    send_item(FUNC_SHOW, 8'h00, 1'b0);
    send_polls(14);
    wait_idle();
    write_timeout(8'd255);
    send_text("FA003600000;");
    send_item(FUNC_SHOW, 8'h00, 1'b0);
    send_polls(14);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    no_idle = 1'b1;
    repeat (10) begin
      send_polls(3);
      send_text("PC123;");
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [7:0] ticks;
    for (int seg = 0; seg < 5; seg++) begin
      wait_idle();
      case (seg)
        0: ticks = 8'd2;
        1: ticks = 8'd255;
        2: ticks = 8'd1;
        3: ticks = 8'($urandom_range(1, 255));
        default: ticks = TIMEOUT_RESET;
      endcase
      write_timeout(ticks);
      no_idle = (seg == 2);
      random_segment(RANDOM_ITEMS / 5);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_replies();
    test_poll_sequence();
    test_reply_timeout();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("PASS transceiver_cat_link_decoder");
    end else begin
      $display("FAIL transceiver_cat_link_decoder");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tcl_pkg.sv
design/tcl_cfg.sv
design/tcl_core.sv
design/transceiver_cat_link_decoder.sv
test/testbench.sv
